// ===== rtl/utf8_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 byte stream decoder.
package utf8_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] QMARK_CP = 21'h00003F;

  // Sequence lengths selected by a lead byte.
  localparam logic [2:0] LEN_BAD  = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            run_last;
    logic            string_end;
  } dec_result_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)          len = LEN_ONE;
    else if (b[7:5] == 3'b110)          len = LEN_TWO;
    else if (b[7:4] == 4'b1110)         len = LEN_THREE;
    else if (b[7:3] == 5'b11110)        len = LEN_FOUR;
    else                                len = LEN_BAD;
    return len;
  endfunction

  // A byte taken alone as a lead: ASCII passes, anything else is '?'.
  function automatic logic [CP_W-1:0] single_cp(input logic [7:0] b);
    return (b[7] == 1'b0) ? {13'd0, b} : QMARK_CP;
  endfunction

  function automatic logic [CP_W-1:0] merge_seq(input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2,
                                                input logic [7:0] b3,
                                                input logic [2:0] len);
    logic [CP_W-1:0] cp;
    unique case (len)
      LEN_ONE:   cp = {13'd0, b0};
      LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
      LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:   cp = QMARK_CP;
    endcase
    return cp;
  endfunction

endpackage

// ===== rtl/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder: byte input register, decode logic, result burst buffer.
//
// Throughput: one byte per cycle while the result buffer has room; the buffer
//   drains one code point per cycle while out_ready is high, so a byte that
//   yields k results holds the input until they have drained. Only a string
//   that ends inside a sequence yields more than one (up to 3).
// Reset (rst, synchronous, active high) empties the input stage and the result
//   buffer and returns the decoder to idle; held bytes are left as they are.
module utf8_byte_stream_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8_pkg::CP_W-1:0]   code_point,
  output logic                        run_last,
  output logic                        string_end
);
  import utf8_pkg::*;

  // ---------------------------------------------------------------------------
  // Input stage: one byte transaction is registered here before decode.
  // ---------------------------------------------------------------------------
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       stg_take;   // stage byte is decoded and its results loaded

  // ---------------------------------------------------------------------------
  // Decoder state: bytes of the sequence in progress, lead first.
  // held_count == 0 means idle.
  // ---------------------------------------------------------------------------
  logic [7:0] held_bytes [3];
  logic [1:0] held_count, held_count_next;
  logic [2:0] needed_total, needed_total_next;
  logic       hold_byte;  // stage byte goes into held_bytes[held_count]

  // ---------------------------------------------------------------------------
  // Result burst buffer: up to three results, entry 0 is presented.
  // ---------------------------------------------------------------------------
  dec_result_t res_buf [3];
  logic [1:0]  res_cnt;
  logic        buf_free;

  // Decode outputs for the stage byte
  dec_result_t dec_res [3];
  logic [1:0]  dec_cnt;

  // Buffer can take a new burst if empty, or if its only entry leaves now.
  assign buf_free = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_ready);
  assign stg_take = stg_valid && buf_free;
  assign in_ready = !stg_valid || stg_take;

  assign out_valid  = (res_cnt != 2'd0);
  assign code_point = res_buf[0].cp;
  assign run_last   = res_buf[0].run_last;
  assign string_end = res_buf[0].string_end;

  // ---------------------------------------------------------------------------
  // Decode: one pass over state and the stage byte.
  // ---------------------------------------------------------------------------
  logic [2:0] lead_len;
  logic [2:0] n_bytes;     // bytes in the sequence including this one
  logic [7:0] seq1, seq2;  // sequence bytes 1 and 2 with the stage byte merged in
  logic [2:0] held1_len;

  always_comb begin
    lead_len  = lead_length(stg_byte);
    n_bytes   = {1'b0, held_count} + 3'd1;
    seq1      = (held_count == 2'd1) ? stg_byte : held_bytes[1];
    seq2      = (held_count == 2'd2) ? stg_byte : held_bytes[2];
    held1_len = lead_length(held_bytes[1]);

    held_count_next   = held_count;
    needed_total_next = needed_total;
    hold_byte         = 1'b0;
    dec_cnt           = 2'd0;
    for (int i = 0; i < 3; i++) begin
      dec_res[i] = '{cp: QMARK_CP, run_last: 1'b0, string_end: 1'b0};
    end

    if (held_count == 2'd0) begin
      // Idle: the byte is a lead.
      if (lead_len == LEN_BAD || lead_len == LEN_ONE) begin
        dec_cnt    = 2'd1;
        dec_res[0] = '{cp: single_cp(stg_byte), run_last: 1'b1, string_end: stg_last};
      end else if (stg_last) begin
        // Multibyte lead with nothing after it
        dec_cnt    = 2'd1;
        dec_res[0] = '{cp: QMARK_CP, run_last: 1'b1, string_end: 1'b1};
      end else begin
        hold_byte         = 1'b1;
        held_count_next   = 2'd1;
        needed_total_next = lead_len;
      end
    end else if (n_bytes == needed_total) begin
      // Sequence complete
      held_count_next   = 2'd0;
      needed_total_next = 3'd0;
      dec_cnt           = 2'd1;
      dec_res[0] = '{cp: merge_seq(held_bytes[0], seq1, seq2, stg_byte, needed_total),
                     run_last: 1'b1, string_end: stg_last};
    end else if (!stg_last) begin
      hold_byte       = 1'b1;
      held_count_next = n_bytes[1:0];
    end else begin
      // String ends inside a sequence: '?' for the lead, then the bytes after
      // the lead are decoded again, starting from a fresh lead.
      held_count_next   = 2'd0;
      needed_total_next = 3'd0;
      if (held_count == 2'd1) begin
        dec_cnt    = 2'd2;
        dec_res[1] = '{cp: single_cp(stg_byte), run_last: 1'b1, string_end: 1'b1};
      end else if (held1_len == LEN_TWO) begin
        dec_cnt    = 2'd2;
        dec_res[1] = '{cp: merge_seq(held_bytes[1], stg_byte, 8'd0, 8'd0, LEN_TWO),
                       run_last: 1'b1, string_end: 1'b1};
      end else begin
        dec_cnt    = 2'd3;
        dec_res[1] = '{cp: single_cp(held_bytes[1]), run_last: 1'b0, string_end: 1'b0};
        dec_res[2] = '{cp: single_cp(stg_byte), run_last: 1'b1, string_end: 1'b1};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte <= in_byte;
      stg_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_total <= 3'd0;
    end else if (stg_take) begin
      held_count   <= held_count_next;
      needed_total <= needed_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take && hold_byte) begin
      held_bytes[held_count] <= stg_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (stg_take) begin
      res_cnt <= dec_cnt;
    end else if (out_valid && out_ready) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      res_buf <= dec_res;
    end else if (out_valid && out_ready) begin
      res_buf[0] <= res_buf[1];
      res_buf[1] <= res_buf[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A sequence in progress always still needs more bytes.
  a_held_below_needed: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) |-> (needed_total > {1'b0, held_count}))
    else $error("held_count not below needed_total");

  // Idle decoder carries no pending length.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (held_count == 2'd0) |-> (needed_total == 3'd0))
    else $error("needed_total set while idle");

  // A three-result burst always opens with '?' for the truncated lead.
  a_burst_qmark: assert property (@(posedge clk) disable iff (rst)
    (stg_take && dec_cnt == 2'd3) |-> (dec_res[0].cp == QMARK_CP))
    else $error("three-result burst without leading replacement");

  // After a result that is not the last of its byte, another follows at once.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !run_last) |=> out_valid)
    else $error("burst ended before run_last");

endmodule

// ===== tb/tb_utf8_byte_stream_decoder.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder.
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder;
  import utf8_pkg::*;

  localparam int CYCLE_LIMIT = 50000;  // well above the slowest legal run
  localparam int SETTLE_CYCLES = 20;   // quiet time after the last code point
  localparam int RX_HOLD_CYCLES = 150; // long sink stall, long enough to back up the input
  localparam int RX_HOLD_AT = 60;      // bytes taken before the long stall starts
  localparam int TEXT_BYTES = 170;

  typedef logic [7:0] seq_t [4];

  typedef struct {
    logic [7:0] val;
    logic       is_last;
    logic       drain_first; // hold this byte back until every code point is out
  } text_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'd0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CP_W-1:0]     code_point;
  logic                run_last;
  logic                string_end;

  // Stimulus and expected code points
  text_byte_t  text_q[$];
  dec_result_t code_points_due[$];

  // Decoder state as the predictor sees it
  logic [7:0] dec_held [3];
  logic [1:0] dec_count = 2'd0;
  logic [2:0] dec_need = 3'd0;

  // Progress counters; all but mismatch_count are updated with nonblocking assignments
  int bytes_taken = 0;
  int cp_predicted = 0;
  int cp_received = 0;
  int cycle_count = 0;
  int rx_hold_left = 0;
  logic rx_hold_done = 1'b0;
  int mismatch_count = 0;

  // No random idling on either side while this window is open.
  logic calm;
  assign calm = (bytes_taken >= 100) && (bytes_taken < 140);

  utf8_byte_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .run_last   (run_last),
    .string_end (string_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [2:0] lead_size(input logic [7:0] b);
    casez (b)
      8'b0???????: return LEN_ONE;
      8'b110?????: return LEN_TWO;
      8'b1110????: return LEN_THREE;
      8'b11110???: return LEN_FOUR;
      default:     return LEN_BAD;
    endcase
  endfunction

  // Lead keeps its payload bits, every following byte adds its low six bits,
  // whatever its top two bits are.
  function automatic logic [CP_W-1:0] join_bytes(input seq_t s, input int unsigned at,
                                                 input logic [2:0] len);
    logic [CP_W-1:0] acc;
    case (len)
      LEN_ONE:   return {13'd0, s[at]};
      LEN_TWO:   acc = {16'd0, s[at][4:0]};
      LEN_THREE: acc = {17'd0, s[at][3:0]};
      LEN_FOUR:  acc = {18'd0, s[at][2:0]};
      default:   return QMARK_CP;
    endcase
    for (int unsigned i = 1; i < len; i++)
      acc = (acc << 6) | {15'd0, s[at + i][5:0]};
    return acc;
  endfunction

  // Feeds one accepted byte through the predictor, queues the code points it
  // causes and returns how many there are.
  function automatic int decode_byte(input logic [7:0] b, input logic fin);
    seq_t        seq;
    dec_result_t res [3];
    logic [2:0]  len;
    int unsigned n, pos, k;
    if (dec_count == 2'd0) begin
      len = lead_size(b);
      if (len == LEN_ONE) begin
        code_points_due.push_back('{{13'd0, b}, 1'b1, fin});
      end else if (len == LEN_BAD || fin) begin
        // bad lead, or a multibyte lead with nothing after it
        code_points_due.push_back('{QMARK_CP, 1'b1, fin});
      end else begin
        dec_held[0] = b;
        dec_count = 2'd1;
        dec_need = len;
        return 0;
      end
      return 1;
    end
    for (int unsigned i = 0; i < dec_count; i++)
      seq[i] = dec_held[i];
    n = dec_count + 1;
    seq[n - 1] = b;
    if (n == dec_need) begin
      code_points_due.push_back('{join_bytes(seq, 0, dec_need), 1'b1, fin});
      dec_count = 2'd0;
      dec_need = 3'd0;
      return 1;
    end
    if (!fin) begin
      dec_held[n - 1] = b;
      dec_count = 2'(n);
      return 0;
    end
    // String cut short inside a sequence: '?' for the lead, then the bytes
    // after it are decoded again, starting from a fresh lead.
    dec_count = 2'd0;
    dec_need = 3'd0;
    res[0] = '{QMARK_CP, 1'b0, 1'b0};
    k = 1;
    pos = 1;
    while (pos < n && k < 3) begin
      len = lead_size(seq[pos]);
      if (len == LEN_BAD || pos + len > n) begin
        res[k] = '{QMARK_CP, 1'b0, 1'b0};
        pos = pos + 1;
      end else begin
        res[k] = '{join_bytes(seq, pos, len), 1'b0, 1'b0};
        pos = pos + len;
      end
      k = k + 1;
    end
    res[k - 1].run_last = 1'b1;
    res[k - 1].string_end = 1'b1;
    for (int unsigned i = 0; i < k; i++)
      code_points_due.push_back(res[i]);
    return k;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic void add_text(input logic [7:0] val, input logic is_last,
                                   input logic drain_first = 1'b0);
    text_q.push_back('{val, is_last, drain_first});
  endfunction

  // One string of mostly well-formed characters, sometimes cut short so that
  // it may end inside a sequence, sometimes with garbage following a lead.
  function automatic void add_random_string(input logic drain_first);
    logic [7:0]  str_q[$];
    logic [2:0]  len;
    logic [7:0]  lead;
    int          kind;
    int          cut;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: str_q.push_back(8'($urandom_range(0, 127)));
        4, 5, 6, 8: begin
          len = 3'($urandom_range(2, 4));
          case (len)
            LEN_TWO:   lead = {3'b110, 5'($urandom)};
            LEN_THREE: lead = {4'b1110, 4'($urandom)};
            default:   lead = {5'b11110, 3'($urandom)};
          endcase
          str_q.push_back(lead);
          for (int i = 1; i < len; i++)
            str_q.push_back(kind == 8 ? 8'($urandom) : {2'b10, 6'($urandom)});
        end
        7: str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                                  : 8'($urandom_range(248, 255)));
        default: str_q.push_back(8'($urandom));
      endcase
    end
    if ($urandom_range(0, 3) == 0 && str_q.size() > 1) begin
      cut = $urandom_range(1, str_q.size() - 1);
      while (str_q.size() > cut)
        void'(str_q.pop_back());
    end
    foreach (str_q[i])
      add_text(str_q[i], i == str_q.size() - 1, drain_first && i == 0);
  endfunction

  function automatic void build_text();
    // ASCII extremes
    add_text(8'h00, 1'b0);
    add_text(8'h7F, 1'b1);
    // overlong two-byte zero, passed through
    add_text(8'hC0, 1'b0);
    add_text(8'h80, 1'b1);
    // three-byte sequence
    add_text(8'hE2, 1'b0);
    add_text(8'h82, 1'b0);
    add_text(8'hAC, 1'b1);
    // largest four-byte value
    add_text(8'hF7, 1'b0);
    add_text(8'hBF, 1'b0);
    add_text(8'hBF, 1'b0);
    add_text(8'hBF, 1'b1);
    // invalid leads: stray continuation, 11111xxx
    add_text(8'h80, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(8'hF8, 1'b1);
    // multibyte lead as the final byte
    add_text(8'hC3, 1'b1);
    // cut-short four-byte: lead, ASCII, then a two-byte lead with no room
    add_text(8'hF0, 1'b0);
    add_text(8'h41, 1'b0);
    add_text(8'hC3, 1'b1);
    // cut-short four-byte whose tail is a complete two-byte sequence
    add_text(8'hF0, 1'b0);
    add_text(8'hC3, 1'b0);
    add_text(8'hA9, 1'b1);
    // surrogate-range lead with non-continuation bytes merged anyway
    add_text(8'hED, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(8'h00, 1'b1);

    // Random part; the first string waits for the pipeline to empty.
    add_random_string(1'b1);
    while (text_q.size() < TEXT_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3))
          add_text(8'($urandom), 1'($urandom));
      end
      add_random_string($urandom_range(0, 9) == 0);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one byte per transaction, predicted at the edge it is taken
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    text_byte_t nxt;
    int         k;
    logic       go;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte <= 8'd0;
      in_last <= 1'b0;
    end else begin
      k = 0;
      if (in_valid && in_ready) begin
        k = decode_byte(in_byte, in_last);
        bytes_taken <= bytes_taken + 1;
        cp_predicted <= cp_predicted + k;
      end
      // Only move on once the offered byte is gone (or nothing is offered).
      if (!in_valid || in_ready) begin
        go = (text_q.size() != 0) && (calm || $urandom_range(0, 99) >= 9);
        // A drain marker stalls the sender until every code point is out.
        if (go && text_q[0].drain_first && (k != 0 || cp_predicted != cp_received))
          go = 1'b0;
        if (go) begin
          nxt = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.val;
          in_last <= nxt.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long sink stall: once, after enough bytes, the receiver stops taking
  // code points so the decoder backs up and drops in_ready.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
      rx_hold_done <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && bytes_taken >= RX_HOLD_AT) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each code point transaction with the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : cp_monitor
    dec_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        cp_received <= cp_received + 1;
        if (code_points_due.size() == 0) begin
          report_mismatch($sformatf("unexpected code point %06h", code_point));
        end else begin
          want = code_points_due.pop_front();
          if (code_point !== want.cp)
            report_mismatch($sformatf("code_point %06h, expected %06h", code_point, want.cp));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b (code point %06h)",
                                      run_last, want.run_last, want.cp));
          if (string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, expected %b (code point %06h)",
                                      string_end, want.string_end, want.cp));
        end
      end
      out_ready <= (rx_hold_left == 0) && (calm || $urandom_range(0, 99) >= 9);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_byte_stream_decoder verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: build text, reset, wait for everything to drain, verdict
  // ---------------------------------------------------------------------
  initial begin
    build_text();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (text_q.size() != 0 || in_valid || cp_predicted != cp_received)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (code_points_due.size() != 0)
      report_mismatch($sformatf("%0d code points never arrived", code_points_due.size()));
    if (mismatch_count == 0)
      $display("utf8_byte_stream_decoder verification clean");
    else
      $display("utf8_byte_stream_decoder verification failed");
    $finish;
  end

endmodule
